[hdl/bkh_pkg.sv]
// Types and constants shared by the bounded k-best max-heap modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bkh_pkg;
    localparam int KIND_W = 2;
    localparam int ID_W   = 31;
    localparam int DIST_W = 32;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;

    localparam int MAX_CAPACITY = 64;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd32;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [DIST_W-1:0] distance;
    } t_entry;

    typedef struct packed {
        t_op               op;
        t_entry            ent;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDSLOT,
        S_LOADM,
        S_DN_RD,
        S_DN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

[hdl/bkh_front.sv]
// Input side: decodes the item kind and holds items in a two-entry queue.
// Depends on bkh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bkh_front
    import bkh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [ID_W-1:0]   i_point_id,
    input  wire logic [DIST_W-1:0] i_distance,
    input  wire logic [SLOT_W-1:0] i_slot,
    output logic                   o_cmd_valid,
    output t_cmd                   o_cmd,
    input  wire logic              i_pop
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.ent.id       = i_point_id;
        w_cmd.ent.distance = i_distance;
        w_cmd.slot         = i_slot;
        unique case (i_kind)
            KIND_INSERT: w_cmd.op = OP_INSERT;
            KIND_CLEAR:  w_cmd.op = OP_CLEAR;
            KIND_READ:   w_cmd.op = OP_READ;
            KIND_NONE:   w_cmd.op = OP_NOP;
            default:     w_cmd.op = OP_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

[hdl/bkh_back.sv]
// Heap engine: heap memory, sift-down/sift-up sequencer and result register.
// Depends on bkh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bkh_back
    import bkh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CNT_W-1:0]  i_cap,
    input  wire logic              i_cmd_valid,
    input  wire t_cmd              i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CNT_W-1:0]       o_count,
    output logic                   o_full_res,
    output logic [DIST_W-1:0]      o_max_distance,
    output logic                   o_taken,
    output logic                   o_read_valid,
    output logic [ID_W-1:0]        o_read_id,
    output logic [DIST_W-1:0]      o_read_distance
);
    localparam int AW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int CW = $clog2(MAX_CAPACITY + 1);

    t_entry r_mem [MAX_CAPACITY];
    t_entry r_qa, r_qb;

    t_state r_st, n_st;
    logic [AW-1:0] r_k, n_k;
    logic [CW-1:0] r_n, n_n, r_cnt, n_cnt;
    t_entry r_m, n_m, r_e, n_e;
    logic signed [DIST_W-1:0] r_max, n_max;
    logic r_fullmode, n_fullmode, r_taken, n_taken;
    logic r_rvalid, n_rvalid;
    t_entry r_rent, n_rent;

    logic r_ovalid;
    logic [CNT_W-1:0] r_ocount;
    logic r_ofull, r_otaken, r_orvalid;
    logic [DIST_W-1:0] r_omax;
    t_entry r_orent;

    logic w_we;
    logic [AW-1:0] w_waddr, w_ra, w_rb;
    t_entry w_wdata;

    logic [31:0] w_cap32, w_eff32, w_cnt32, w_n32, w_c32, w_slot32;
    logic w_full, w_dn_leaf, w_sel_b, w_dn_stop, w_up_stop, w_start;
    logic w_rd_ok, w_ins_take;
    t_entry w_sel;
    logic [AW-1:0] w_sel_idx, w_par;

    assign w_cap32  = 32'(i_cap);
    assign w_eff32  = (w_cap32 == 32'd0) ? 32'd1 :
                      (w_cap32 > MAX_CAPACITY) ? 32'(MAX_CAPACITY) : w_cap32;
    assign w_cnt32  = 32'(r_cnt);
    assign w_full   = (w_cnt32 >= w_eff32);
    assign w_n32    = 32'(r_n);
    assign w_c32    = 32'({r_k, 1'b1});
    assign w_slot32 = 32'(i_cmd.slot);

    assign w_start    = (r_st == S_IDLE) && i_cmd_valid && !r_ovalid;
    assign w_rd_ok    = (w_slot32 < w_cnt32) && (w_slot32 < MAX_CAPACITY);
    assign w_ins_take = !w_full || ($signed(i_cmd.ent.distance) < r_max);

    assign w_dn_leaf = (w_c32 >= w_n32);
    assign w_sel_b   = ((w_c32 + 32'd1) < w_n32) &&
                       ($signed(r_qa.distance) < $signed(r_qb.distance));
    assign w_sel     = w_sel_b ? r_qb : r_qa;
    assign w_sel_idx = w_sel_b ? AW'(w_c32 + 32'd1) : AW'(w_c32);
    assign w_dn_stop = !($signed(r_m.distance) < $signed(w_sel.distance));
    assign w_par     = (r_k - AW'(1)) >> 1;
    assign w_up_stop = !($signed(r_qa.distance) < $signed(r_e.distance));

    assign o_pop = w_start;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (w_start) begin
                    priority if (i_cmd.op == OP_INSERT && !w_ins_take) n_st = S_DONE;
                    else if (i_cmd.op == OP_INSERT && !w_full) n_st = S_UP_RD;
                    else if (i_cmd.op == OP_INSERT) n_st = S_LOADM;
                    else if (i_cmd.op == OP_READ && w_rd_ok) n_st = S_RDSLOT;
                    else n_st = S_DONE;
                end
            end
            S_RDSLOT: n_st = S_DONE;
            S_LOADM:  n_st = S_DN_RD;
            S_DN_RD:  n_st = w_dn_leaf ? S_UP_RD : S_DN_CMP;
            S_DN_CMP: n_st = w_dn_stop ? S_UP_RD : S_DN_RD;
            S_UP_RD:  n_st = (r_k == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP: n_st = w_up_stop ? S_DONE : S_UP_RD;
            S_DONE:   n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    always_comb begin
        n_k        = r_k;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_m        = r_m;
        n_e        = r_e;
        n_max      = r_max;
        n_fullmode = r_fullmode;
        n_taken    = r_taken;
        n_rvalid   = r_rvalid;
        n_rent     = r_rent;
        w_we       = 1'b0;
        w_waddr    = r_k;
        w_wdata    = r_m;
        w_ra       = r_k;
        w_rb       = r_k;
        unique case (r_st)
            S_IDLE: begin
                if (w_start) begin
                    n_taken  = 1'b0;
                    n_rvalid = 1'b0;
                    n_rent   = '0;
                    n_e      = i_cmd.ent;
                    w_ra     = AW'(i_cmd.slot);
                    unique case (i_cmd.op)
                        OP_INSERT: begin
                            if (!w_full) begin
                                if ($signed(i_cmd.ent.distance) > r_max) begin
                                    n_max = i_cmd.ent.distance;
                                end
                                n_k        = AW'(r_cnt);
                                n_cnt      = r_cnt + CW'(1);
                                n_taken    = 1'b1;
                                n_fullmode = 1'b0;
                            end else if (w_ins_take) begin
                                n_n        = r_cnt - CW'(1);
                                w_ra       = AW'(r_cnt - CW'(1));
                                n_k        = '0;
                                n_taken    = 1'b1;
                                n_fullmode = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt = '0;
                            n_max = DIST_MIN;
                        end
                        OP_READ, OP_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDSLOT: begin
                n_rvalid = 1'b1;
                n_rent   = r_qa;
            end
            S_LOADM: begin
                n_m = r_qa;
            end
            S_DN_RD: begin
                w_ra = AW'(w_c32);
                w_rb = AW'(w_c32 + 32'd1);
                if (w_dn_leaf) begin
                    w_we    = 1'b1;
                    w_wdata = r_m;
                    if (r_k == '0) begin
                        n_max = r_m.distance;
                    end
                    n_k = AW'(r_n);
                end
            end
            S_DN_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_dn_stop ? r_m : w_sel;
                if (r_k == '0) begin
                    n_max = w_wdata.distance;
                end
                n_k = w_dn_stop ? AW'(r_n) : w_sel_idx;
            end
            S_UP_RD: begin
                w_ra = w_par;
                if (r_k == '0) begin
                    w_we    = 1'b1;
                    w_wdata = r_e;
                    if (r_fullmode) begin
                        n_max = r_e.distance;
                    end
                end
            end
            S_UP_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_up_stop ? r_e : r_qa;
                if (!w_up_stop) begin
                    n_k = w_par;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_qa <= r_mem[w_ra];
        r_qb <= r_mem[w_rb];
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_n    <= n_n;
        r_m    <= n_m;
        r_e    <= n_e;
        r_rent <= n_rent;
        if (r_st == S_DONE) begin
            r_ocount  <= CNT_W'(r_cnt);
            r_ofull   <= w_full;
            r_omax    <= r_max;
            r_otaken  <= r_taken;
            r_orvalid <= r_rvalid;
            r_orent   <= r_rent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_cnt      <= '0;
            r_max      <= DIST_MIN;
            r_fullmode <= 1'b0;
            r_taken    <= 1'b0;
            r_rvalid   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_cnt      <= n_cnt;
            r_max      <= n_max;
            r_fullmode <= n_fullmode;
            r_taken    <= n_taken;
            r_rvalid   <= n_rvalid;
            if (r_st == S_DONE) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_ovalid;
    assign o_count         = r_ocount;
    assign o_full_res      = r_ofull;
    assign o_max_distance  = r_omax;
    assign o_taken         = r_otaken;
    assign o_read_valid    = r_orvalid;
    assign o_read_id       = r_orent.id;
    assign o_read_distance = r_orent.distance;
endmodule
`default_nettype wire

[hdl/bounded_kbest_max_heap.sv]
// Bounded k-best max-heap top level: capacity register, input queue and heap engine.
// Depends on bkh_pkg, bkh_front and bkh_back.
//
// Usage: items enter on i_valid/o_ready (kind, point id, Q16.16 distance, slot);
// one result leaves per item on o_valid/i_ready. The user must write the capacity
// register through i_cfg_valid/o_cfg_ready/i_cfg_data only while the block is idle;
// the block itself does not enforce it. A read fetches its slot from the heap
// memory. An insert into a heap that is not full climbs from the new last slot
// towards the root; a replacing insert sifts the last entry down from the root,
// then climbs the new entry up from the last slot. The single heap memory with
// one write and two reads a cycle serves these steps.
// Items are worked one at a time: the engine takes the next queued item in the
// cycle after the result is taken. A two-entry input queue keeps taking items
// while the engine is busy.
// Reset empties the heap, sets the tracked maximum to the most negative value
// and capacity to 32. The heap memory itself is not cleared. When the receiver
// stalls, the result register holds and the engine waits before the next item.
`timescale 1ns / 1ps
`default_nettype none
module bounded_kbest_max_heap
    import bkh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [ID_W-1:0]   i_point_id,
    input  wire logic [DIST_W-1:0] i_distance,
    input  wire logic [SLOT_W-1:0] i_slot,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [CNT_W-1:0]       o_count,
    output logic                   o_full_res,
    output logic [DIST_W-1:0]      o_max_distance,
    output logic                   o_taken,
    output logic                   o_read_valid,
    output logic [ID_W-1:0]        o_read_id,
    output logic [DIST_W-1:0]      o_read_distance
);
    logic [CNT_W-1:0] r_cap;
    logic w_cmd_valid, w_pop;
    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    bkh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_point_id  (i_point_id),
        .i_distance  (i_distance),
        .i_slot      (i_slot),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_pop       (w_pop)
    );

    bkh_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cap           (r_cap),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_count         (o_count),
        .o_full_res      (o_full_res),
        .o_max_distance  (o_max_distance),
        .o_taken         (o_taken),
        .o_read_valid    (o_read_valid),
        .o_read_id       (o_read_id),
        .o_read_distance (o_read_distance)
    );

    a_taken_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_taken |-> o_count != '0)
        else $error("taken insert with empty heap");

    a_read_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_read_valid |-> !o_taken && o_count != '0)
        else $error("read result flags inconsistent");

    a_empty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_count == '0 |-> o_max_distance == DIST_MIN && !o_read_valid)
        else $error("empty heap reports a maximum or a read");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd_valid && !o_valid)
        else $error("engine took an item from an empty queue or while holding a result");
endmodule
`default_nettype wire
